>>> rtl/tac_pkg.sv
// shared constants, types and tables for the temperature compensated tilt unit
// no dependencies; used by every other file in rtl
package tac_pkg;

  localparam int ATAN_ITERATIONS_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int TAB_LEN             = 24;

  localparam int IW   = 16;
  localparam int XW   = 42;
  localparam int AW   = 42;
  localparam int OFFW = 42;
  localparam int DW   = 44;
  localparam int NW   = 51;
  localparam int QW   = 16;
  localparam int OW   = 17;

  localparam int CORDIC_SHIFT = 24;
  localparam int RECIP_SHIFT  = 24;
  localparam logic [15:0] RECIP_340 = 16'd49345;

  // 1e10 = 2^10 * 9765625; the odd part is divided by a reciprocal multiply
  localparam int          DIV_LO_SHIFT    = 10;
  localparam int          DIV_HI_SHIFT    = 16;
  localparam int          DIV_RECIP_SHIFT = 24;
  localparam logic [23:0] DIV_ODD         = 24'd9765625;
  localparam logic [16:0] DIV_RECIP       = 17'((64'sd1 <<< 40) / 64'sd9765625);

  localparam longint UNITS_PER_DEG = 64'sd10000000000;
  localparam longint DEG90         = 64'sd900000000000;

  localparam logic [1:0] SP_NONE  = 2'd0;
  localparam logic [1:0] SP_ZERO  = 2'd1;
  localparam logic [1:0] SP_POS90 = 2'd2;
  localparam logic [1:0] SP_NEG90 = 2'd3;

  typedef logic signed [XW-1:0]   vec_t;
  typedef logic signed [AW-1:0]   ang_t;
  typedef logic signed [OFFW-1:0] off_t;

  typedef struct packed {
    off_t       off;
    logic [1:0] code;
    logic       undef;
  } side_t;

  typedef off_t off_tab_t [256];

  // atan(2^-i) in units of 1e-10 degree
  function automatic ang_t atan_tab(input int i);
    case (i)
      0:  return 42'sd450000000000;
      1:  return 42'sd265650511770;
      2:  return 42'sd140362434680;
      3:  return 42'sd71250163490;
      4:  return 42'sd35763343750;
      5:  return 42'sd17899106080;
      6:  return 42'sd8951737100;
      7:  return 42'sd4476141710;
      8:  return 42'sd2238105000;
      9:  return 42'sd1119056770;
      10: return 42'sd559528920;
      11: return 42'sd279764530;
      12: return 42'sd139882270;
      13: return 42'sd69941140;
      14: return 42'sd34970570;
      15: return 42'sd17485280;
      16: return 42'sd8742640;
      17: return 42'sd4371320;
      18: return 42'sd2185660;
      19: return 42'sd1092830;
      20: return 42'sd546420;
      21: return 42'sd273210;
      22: return 42'sd136600;
      23: return 42'sd68300;
      default: return '0;
    endcase
  endfunction

  // offsets indexed by whole degrees plus 64
  function automatic off_tab_t mk_off_lat();
    off_tab_t tab;
    longint   t;
    longint   v;
    for (int idx = 0; idx < 256; idx++) begin
      t = longint'(idx) - 64;
      v = (((-444 * t + 74540) * t - 2898000) * t - 106100000) * t + 159100000;
      tab[idx] = OFFW'(v);
    end
    return tab;
  endfunction

  function automatic off_tab_t mk_off_front();
    off_tab_t tab;
    longint   t;
    longint   v;
    for (int idx = 0; idx < 256; idx++) begin
      t = longint'(idx) - 64;
      v = ((231300 * t - 44590000) * t + 64'sd2771000000) * t - 64'sd50540000000;
      tab[idx] = OFFW'(v);
    end
    return tab;
  endfunction

  localparam off_tab_t OFF_LAT_TAB   = mk_off_lat();
  localparam off_tab_t OFF_FRONT_TAB = mk_off_front();

endpackage

>>> rtl/tac_if.sv
// handshake interfaces for the sample and result channels
// depends on tac_pkg for field widths
interface tac_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [tac_pkg::IW-1:0]  accel_x;
  logic signed [tac_pkg::IW-1:0]  accel_y;
  logic signed [tac_pkg::IW-1:0]  accel_z;
  logic signed [tac_pkg::IW-1:0]  temp_raw;

  modport source (output valid, accel_x, accel_y, accel_z, temp_raw, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, temp_raw, output ready);
endinterface

interface tac_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [tac_pkg::OW-1:0]  lateral_angle;
  logic signed [tac_pkg::OW-1:0]  frontal_angle;
  logic                           undefined_ratio;

  modport source (output valid, lateral_angle, frontal_angle, undefined_ratio,
                  input ready);
  modport sink   (input valid, lateral_angle, frontal_angle, undefined_ratio,
                  output ready);
endinterface

>>> rtl/tac_prep.sv
// input stages: cordic start vectors, special cases, temperature to offsets
// depends on tac_pkg
module tac_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [tac_pkg::IW-1:0] ax,
  input  logic signed [tac_pkg::IW-1:0] ay,
  input  logic signed [tac_pkg::IW-1:0] az,
  input  logic signed [tac_pkg::IW-1:0] traw,
  output logic                          vld_o,
  output tac_pkg::vec_t                 lat_x_o,
  output tac_pkg::vec_t                 lat_y_o,
  output tac_pkg::vec_t                 front_x_o,
  output tac_pkg::vec_t                 front_y_o,
  output tac_pkg::side_t                lat_side_o,
  output tac_pkg::side_t                front_side_o
);
  import tac_pkg::*;

  function automatic logic [1:0] spec_code(input logic signed [IW-1:0] n,
                                           input logic zz);
    if (zz) begin
      if (n > 0) return SP_POS90;
      else if (n < 0) return SP_NEG90;
      else return SP_ZERO;
    end else if (n == 0) begin
      return SP_ZERO;
    end else begin
      return SP_NONE;
    end
  endfunction

  logic signed [IW:0] az_e, ax_e, ay_e, tr_e;
  logic signed [IW:0] z_mag, nx, ny;
  logic [IW:0]        t_mag;

  logic               vld1_r;
  logic [32:0]        prod_r, prod_nxt;
  logic               tneg_r;
  vec_t               lx_r, ly_r, fx_r, fy_r;
  logic [1:0]         lcode_r, fcode_r;
  logic               undef_r;

  always_comb begin
    az_e  = {az[IW-1], az};
    ax_e  = {ax[IW-1], ax};
    ay_e  = {ay[IW-1], ay};
    tr_e  = {traw[IW-1], traw};
    z_mag = (az_e < 0) ? -az_e : az_e;
    nx    = (az_e < 0) ? -ax_e : ax_e;
    ny    = (az_e < 0) ? -ay_e : ay_e;
    t_mag = (tr_e < 0) ? (IW+1)'(-tr_e) : (IW+1)'(tr_e);
    prod_nxt = 33'(t_mag) * 33'(RECIP_340);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      tneg_r  <= traw[IW-1];
      lx_r    <= vec_t'(z_mag) <<< CORDIC_SHIFT;
      ly_r    <= vec_t'(nx) <<< CORDIC_SHIFT;
      fx_r    <= vec_t'(z_mag) <<< CORDIC_SHIFT;
      fy_r    <= vec_t'(ny) <<< CORDIC_SHIFT;
      lcode_r <= spec_code(ax, az == '0);
      fcode_r <= spec_code(ay, az == '0);
      undef_r <= (az == '0) && ((ax == '0) || (ay == '0));
    end
  end

  // whole degrees: q = raw/340 toward zero, then plus 36.53 truncated
  logic [8:0]        qa;
  logic signed [9:0] q, idxw;
  logic [7:0]        idx;

  always_comb begin
    qa   = prod_r[32:RECIP_SHIFT];
    q    = tneg_r ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
    idxw = q + 10'sd100 + ((q < -10'sd36) ? 10'sd1 : 10'sd0);
    idx  = idxw[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat_x_o              <= lx_r;
      lat_y_o              <= ly_r;
      front_x_o            <= fx_r;
      front_y_o            <= fy_r;
      lat_side_o.off       <= OFF_LAT_TAB[idx];
      lat_side_o.code      <= lcode_r;
      lat_side_o.undef     <= undef_r;
      front_side_o.off     <= OFF_FRONT_TAB[idx];
      front_side_o.code    <= fcode_r;
      front_side_o.undef   <= undef_r;
    end
  end

endmodule

>>> rtl/tac_cordic.sv
// vectoring cordic pipeline, one rotation per register stage
// depends on tac_pkg
module tac_cordic #(
  parameter int NSTG = tac_pkg::ATAN_ITERATIONS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  tac_pkg::vec_t  x_i,
  input  tac_pkg::vec_t  y_i,
  input  tac_pkg::side_t side_i,
  output logic           vld_o,
  output tac_pkg::ang_t  ang_o,
  output tac_pkg::side_t side_o
);
  import tac_pkg::*;

  vec_t            x_r [NSTG];
  vec_t            y_r [NSTG];
  ang_t            a_r [NSTG];
  side_t           s_r [NSTG];
  logic [NSTG-1:0] v_r;

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    vec_t  xin, yin, x_nxt, y_nxt;
    ang_t  ain, a_nxt;
    side_t sin;
    logic  vin;

    if (i == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign ain = '0;
      assign sin = side_i;
      assign vin = vld_i;
    end else begin : g_rest
      assign xin = x_r[i-1];
      assign yin = y_r[i-1];
      assign ain = a_r[i-1];
      assign sin = s_r[i-1];
      assign vin = v_r[i-1];
    end

    always_comb begin
      if (yin >= 0) begin
        x_nxt = xin + (yin >>> i);
        y_nxt = yin - (xin >>> i);
        a_nxt = ain + atan_tab(i);
      end else begin
        x_nxt = xin - (yin >>> i);
        y_nxt = yin + (xin >>> i);
        a_nxt = ain - atan_tab(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        a_r[i] <= a_nxt;
        s_r[i] <= sin;
      end
    end
  end

  assign vld_o  = v_r[NSTG-1];
  assign ang_o  = a_r[NSTG-1];
  assign side_o = s_r[NSTG-1];

endmodule

>>> rtl/tac_scale.sv
// offset subtract, saturation and rounding to fixed point degrees
// division by 1e10 as a shift and a reciprocal multiply with correction; depends on tac_pkg
module tac_scale #(
  parameter int FRAC = tac_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  tac_pkg::ang_t                 ang_i,
  input  tac_pkg::side_t                side_i,
  output logic                          vld_o,
  output logic signed [tac_pkg::OW-1:0] angle_o,
  output logic                          flag_o
);
  import tac_pkg::*;

  localparam longint LIM_RAW = 64'sd180 <<< FRAC;
  localparam longint LIM     = (LIM_RAW > 65535) ? 64'sd65535 : LIM_RAW;
  localparam longint HALF    = UNITS_PER_DEG / 2;
  localparam longint M_THR   =
    ((LIM + 1) * UNITS_PER_DEG - HALF + (64'sd1 <<< FRAC) - 1) >>> FRAC;
  localparam int     MW      = DW + FRAC;
  localparam int     NLW     = NW - DIV_LO_SHIFT;
  localparam int     NHW     = NLW - DIV_HI_SHIFT;
  localparam int     PW      = NHW + 17;
  localparam int     EW      = PW - DIV_RECIP_SHIFT;
  localparam int     RW      = EW + 24;

  // stage a: pick arctangent term, subtract offset
  ang_t                 sel;
  logic signed [DW-1:0] diff_nxt, diff_r;
  logic                 va_r, fa_r;

  always_comb begin
    case (side_i.code)
      SP_NONE:  sel = ang_i;
      SP_ZERO:  sel = '0;
      SP_POS90: sel = AW'(DEG90);
      SP_NEG90: sel = AW'(-DEG90);
      default:  sel = '0;
    endcase
    diff_nxt = DW'(sel) - DW'(side_i.off);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      fa_r   <= side_i.undef;
    end
  end

  // stage b: magnitude, saturation test, dividend
  logic [DW-1:0] mag;
  logic [MW-1:0] num_w;
  logic          vb_r, fb_r, nb_r, sb_r;
  logic [NW-1:0] numb_r;

  always_comb begin
    mag   = (diff_r < 0) ? DW'(-diff_r) : DW'(diff_r);
    num_w = (MW'(mag) << FRAC) + MW'(HALF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fb_r   <= fa_r;
      nb_r   <= diff_r < 0;
      sb_r   <= {{(64-DW){1'b0}}, mag} >= 64'(M_THR);
      numb_r <= NW'(num_w);
    end
  end

  // stage c: drop the power of two, estimate quotient from the upper bits
  logic [NLW-1:0] nlc_r;
  logic [PW-1:0]  pc_r;
  logic           vc_r, fc_r, nc_r, sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nlc_r <= numb_r[NW-1:DIV_LO_SHIFT];
      pc_r  <= PW'(numb_r[NW-1:NW-NHW]) * PW'(DIV_RECIP);
      fc_r  <= fb_r;
      nc_r  <= nb_r;
      sc_r  <= sb_r;
    end
  end

  // stage d: estimate times divisor
  logic [NLW-1:0] nld_r;
  logic [EW-1:0]  qed_r;
  logic [RW-1:0]  qdd_r;
  logic [EW-1:0]  qe_w;
  logic           vd_r, fd_r, nd_r, sd_r;

  assign qe_w = pc_r[PW-1:DIV_RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nld_r <= nlc_r;
      qed_r <= qe_w;
      qdd_r <= RW'(qe_w) * RW'(DIV_ODD);
      fd_r  <= fc_r;
      nd_r  <= nc_r;
      sd_r  <= sc_r;
    end
  end

  // stage e: the estimate is low by at most two
  logic [RW-1:0] rem;
  logic [EW-1:0] qfix;
  logic [QW-1:0] qe_r;
  logic          ve_r, fe_r, ne_r, se_r;

  always_comb begin
    rem = RW'(nld_r) - qdd_r;
    if (rem >= (RW'(DIV_ODD) << 1)) begin
      qfix = qed_r + EW'(2);
    end else if (rem >= RW'(DIV_ODD)) begin
      qfix = qed_r + EW'(1);
    end else begin
      qfix = qed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qe_r <= qfix[QW-1:0];
      fe_r <= fd_r;
      ne_r <= nd_r;
      se_r <= sd_r;
    end
  end

  // result register
  logic [QW-1:0]        qsat;
  logic signed [OW-1:0] angle_nxt;

  always_comb begin
    qsat      = se_r ? QW'(LIM) : qe_r;
    angle_nxt = ne_r ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_o <= angle_nxt;
      flag_o  <= fe_r;
    end
  end

endmodule

>>> rtl/tilt_angle_temp_compensated_unit.sv
// Temperature compensated tilt unit: takes one accelerometer and temperature
// word per cycle while the output is not stalled and returns lateral and
// frontal tilt in fixed point degrees. The pipeline has prep, cordic and scale
// stages; the cordic runs one iteration per stage, capped at 24, and the scale
// stages use three for the reciprocal division by 1e10. The whole pipeline
// holds while a result waits.
// depends on tac_pkg, tac_if, tac_prep, tac_cordic, tac_scale
module tilt_angle_temp_compensated_unit #(
  parameter int ATAN_ITERATIONS = tac_pkg::ATAN_ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS = tac_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tac_in_if.sink    in_ch,
  tac_out_if.source out_ch
);
  import tac_pkg::*;

  localparam int NSTG = (ATAN_ITERATIONS > TAB_LEN) ? TAB_LEN : ATAN_ITERATIONS;

  logic  en;
  logic  p_vld, c_vld;
  vec_t  lx, ly, fx, fy;
  side_t ls, fs, lso, fso;
  ang_t  la, fa;
  logic  lat_vld, lat_flag;
  logic signed [OW-1:0] lat_ang, front_ang;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  tac_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .vld_i        (in_ch.valid),
    .ax           (in_ch.accel_x),
    .ay           (in_ch.accel_y),
    .az           (in_ch.accel_z),
    .traw         (in_ch.temp_raw),
    .vld_o        (p_vld),
    .lat_x_o      (lx),
    .lat_y_o      (ly),
    .front_x_o    (fx),
    .front_y_o    (fy),
    .lat_side_o   (ls),
    .front_side_o (fs)
  );

  tac_cordic #(.NSTG(NSTG)) u_cordic_lat (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (p_vld),
    .x_i    (lx),
    .y_i    (ly),
    .side_i (ls),
    .vld_o  (c_vld),
    .ang_o  (la),
    .side_o (lso)
  );

  tac_cordic #(.NSTG(NSTG)) u_cordic_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (p_vld),
    .x_i    (fx),
    .y_i    (fy),
    .side_i (fs),
    .vld_o  (),
    .ang_o  (fa),
    .side_o (fso)
  );

  tac_scale #(.FRAC(ANGLE_FRAC_BITS)) u_scale_lat (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (c_vld),
    .ang_i   (la),
    .side_i  (lso),
    .vld_o   (lat_vld),
    .angle_o (lat_ang),
    .flag_o  (lat_flag)
  );

  tac_scale #(.FRAC(ANGLE_FRAC_BITS)) u_scale_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (c_vld),
    .ang_i   (fa),
    .side_i  (fso),
    .vld_o   (),
    .angle_o (front_ang),
    .flag_o  ()
  );

  assign out_ch.valid           = lat_vld;
  assign out_ch.lateral_angle   = lat_ang;
  assign out_ch.frontal_angle   = front_ang;
  assign out_ch.undefined_ratio = lat_flag;

endmodule

>>> tb/sv/tb_tilt_angle_temp_compensated_unit.sv
`timescale 1ns / 1ps
// testbench for tilt_angle_temp_compensated_unit: drives random and directed words,
// predicts compensated tilt angles and checks every result in order
// depends on tac_pkg, tac_if and the rtl of the unit
module tb_tilt_angle_temp_compensated_unit;
  import tac_pkg::*;

  localparam int ITERS = ATAN_ITERATIONS_DEF;
  localparam int FRAC = ANGLE_FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [OW-1:0] lateral;
    logic signed [OW-1:0] frontal;
    logic                 undef;
  } tilt_t;

  class tilt_scoreboard;
    tilt_t pending[$];
    int    errors;
    int    checked;

    function longint tilt_atan(longint n, longint z, ref bit undef);
      longint x, y, ang, dx, dy;
      ang = 0;
      if (z == 0) begin
        if (n == 0) begin
          undef = 1;
          return 0;
        end
        return (n > 0) ? DEG90 : -DEG90;
      end
      if (n == 0) return 0;
      if (z < 0) begin
        z = -z;
        n = -n;
      end
      x = z <<< CORDIC_SHIFT;
      y = n <<< CORDIC_SHIFT;
      for (int i = 0; i < ITERS && i < TAB_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; ang += longint'(atan_tab(i));
        end else begin
          x -= dx; y += dy; ang -= longint'(atan_tab(i));
        end
      end
      return ang;
    endfunction

    function logic signed [OW-1:0] deg_to_fixed(longint v);
      longint m, lim, q;
      m = (v < 0) ? -v : v;
      lim = longint'(180) << FRAC;
      if (lim > 65535) lim = 65535;
      if (m > 400 * UNITS_PER_DEG) q = lim;
      else begin
        q = (m * (longint'(1) << FRAC) + UNITS_PER_DEG / 2) / UNITS_PER_DEG;
        if (q > lim) q = lim;
      end
      return OW'((v < 0) ? -q : q);
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic signed [15:0] traw);
      longint q, t, off_lat, off_front, lat, front;
      bit     undef;
      tilt_t  e;
      undef = 0;
      q = longint'(traw) / 340;
      t = (q >= -36) ? q + 36 : q + 37;
      off_lat = (((-444 * t + 74540) * t - 2898000) * t - 106100000) * t + 159100000;
      off_front = ((231300 * t - 44590000) * t + 64'sd2771000000) * t
                  - 64'sd50540000000;
      lat = tilt_atan(longint'(ax), longint'(az), undef) - off_lat;
      front = tilt_atan(longint'(ay), longint'(az), undef) - off_front;
      e.lateral = deg_to_fixed(lat);
      e.frontal = deg_to_fixed(front);
      e.undef = undef;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [OW-1:0] lat, logic signed [OW-1:0] front,
                               logic undef);
      tilt_t e;
      if (pending.size() == 0) begin
        $error("result with no sample pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (lat !== e.lateral) begin
        $error("lateral_angle expected %0d actual %0d", e.lateral, lat);
        errors++;
      end
      if (front !== e.frontal) begin
        $error("frontal_angle expected %0d actual %0d", e.frontal, front);
        errors++;
      end
      if (undef !== e.undef) begin
        $error("undefined_ratio expected %0d actual %0d", e.undef, undef);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tac_in_if  in_ch();
  tac_out_if out_ch();

  tilt_angle_temp_compensated_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  tilt_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;
  int sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_sample(in_ch.accel_x, in_ch.accel_y, in_ch.accel_z, in_ch.temp_raw);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.lateral_angle, out_ch.frontal_angle, out_ch.undefined_ratio);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                           logic [15:0] traw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.accel_x = ax;
    in_ch.accel_y = ay;
    in_ch.accel_z = az;
    in_ch.temp_raw = traw;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_temp();
    case ($urandom_range(5))
      0: return 16'($signed($urandom_range(680)) - 12580);
      1: return 16'($signed($urandom_range(40000)) - 20000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    logic [15:0] ax, ay, az;
    for (int i = 0; i < count; i++) begin
      ax = rand_field();
      ay = rand_field();
      az = ($urandom_range(7) == 0) ? 16'h0000 : rand_field();
      send_word(ax, ay, az, rand_temp());
    end
  endtask

  initial begin
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.accel_x = 0;
    in_ch.accel_y = 0;
    in_ch.accel_z = 0;
    in_ch.temp_raw = 0;
    out_ch.ready = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent = 0;
    stall_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed corners: zero over zero, vertical, signs, extremes, temperature edges
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'd5, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'hfffb, 16'd7, 16'h0000, 16'h0000);
    send_word(16'h0000, 16'h0000, 16'd100, 16'h0000);
    send_word(16'h0000, 16'd9, 16'hff00, 16'h0000);
    send_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(16'h7fff, 16'h8000, 16'h0001, 16'h7fff);
    send_word(16'h8000, 16'h7fff, 16'hffff, 16'h8000);
    send_word(16'h0001, 16'hffff, 16'h8000, 16'h0000);
    send_word(16'd1000, 16'd2000, 16'd1000, 16'($signed(-12240)));
    send_word(16'd1000, 16'd2000, 16'd1000, 16'($signed(-12580)));
    send_word(16'd300, 16'hff00, 16'd400, 16'($signed(-12241)));
    send_word(16'd300, 16'hff00, 16'd400, 16'd339);
    send_word(16'd300, 16'hff00, 16'd400, 16'($signed(-339)));
    send_word(16'd340, 16'd340, 16'd340, 16'd340);
    send_word(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_word(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    drain();

    send_idle_pct = 24;
    recv_idle_pct = 75;
    send_random(380);
    drain();
    send_idle_pct = 75;
    recv_idle_pct = 24;
    send_random(380);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(380);
    drain();
    repeat (40) @(posedge clk);

    $display("sent %0d samples, checked %0d results across three stall profiles",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/tac_pkg.sv
rtl/tac_if.sv
rtl/tac_prep.sv
rtl/tac_cordic.sv
rtl/tac_scale.sv
rtl/tilt_angle_temp_compensated_unit.sv
tb/sv/tb_tilt_angle_temp_compensated_unit.sv
